[rtl/olde_pkg.sv]
// Shared constants and helpers for the ordered list deque engine.
// Holds the capacity, the derived widths, the command and status codes.
// Has no dependencies; every file of the block imports it.
package olde_pkg;

  // Number of entries the list can hold.
  localparam int unsigned CAPACITY = 16;

  // Index width, count width and width for position compares.
  localparam int unsigned CAP_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  // Field widths of the stream beats.
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STS_W    = 3;
  localparam int unsigned OUTCNT_W = 5;
  localparam int unsigned IN_W     = 48;
  localparam int unsigned OUT_W    = 48;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_EMPTY    = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL     = 3'd2;
  localparam logic [STS_W-1:0] STS_BADPOS   = 3'd3;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd4;

  // Fit a count into the five-bit result fields, dropping upper bits.
  function automatic logic [OUTCNT_W-1:0] fit_count(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OUTCNT_W-1:0];
  endfunction

endpackage

[rtl/ordered_list_deque_engine_core.sv]
// Top level of the ordered list deque engine: entry memory and sequencer.
// Depends on olde_pkg for the capacity, widths and command/status codes.
//
// Usage:
//   Commands arrive as beats on the s_axis group; each command yields exactly
//   one result beat on the m_axis group. The block works on one command at a
//   time: s_axis_tready is high only while it is idle.
//   The entries sit in a small single-port-style memory (one read and one
//   write per cycle, registered read data). A sequencer moves one entry at a
//   time through that port, a read state then a write state, and one
//   comparator walks the list on find. Push and insert move the entries at
//   and above the slot up by one, top first, then write the value; pop and
//   delete read the entry at the slot, then move the entries above it down
//   by one, bottom first; find compares from the front until a match or the
//   end. Rejected commands and command code seven go straight to the result
//   beat.
//   The next command is taken the cycle after the result beat is taken.
//   Reset clears the element count and the sequencer; entry contents are
//   left as they are and are never read before being written.
//   While the receiver holds m_axis_tready low the result beat stays stable
//   and no new command is accepted.
module ordered_list_deque_engine_core
  import olde_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Fields from bit 0: command[2:0], position[10:3], operand_value[42:11].
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: popped_value[31:0], found_position[36:32],
  // status[39:37], element_count[44:40], is_empty[45].
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready
);

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INS_RD   = 4'd1;
  localparam logic [3:0] ST_INS_WR   = 4'd2;
  localparam logic [3:0] ST_TAKE     = 4'd3;
  localparam logic [3:0] ST_TAKE_CAP = 4'd4;
  localparam logic [3:0] ST_DEL_RD   = 4'd5;
  localparam logic [3:0] ST_DEL_WR   = 4'd6;
  localparam logic [3:0] ST_FIND_RD  = 4'd7;
  localparam logic [3:0] ST_FIND_CMP = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CAP_W-1:0] at_q, at_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             is_pop_q, is_pop_d;
  logic [VAL_W-1:0] popped_q, popped_d;
  logic [CNT_W-1:0] found_q, found_d;
  logic [STS_W-1:0] status_q, status_d;

  // Entry memory port signals.
  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic             rd_en;
  logic [CAP_W-1:0] rd_addr;
  logic [VAL_W-1:0] rdata_q;
  logic             wr_en;
  logic [CAP_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  // Unpacked input beat fields.
  logic [CMD_W-1:0] in_cmd;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  logic [CMP_W-1:0] pos_w, occ_w;
  logic             full, empty;

  assign in_cmd = s_axis_tdata[CMD_W-1:0];
  assign in_pos = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_val = s_axis_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];
  assign pos_w  = CMP_W'(in_pos);
  assign occ_w  = CMP_W'(occ_q);
  assign full   = (occ_q == CNT_W'(CAPACITY));
  assign empty  = (occ_q == '0);

  // Handshake outputs and result beat packing.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {2'b00, empty, fit_count(occ_q), status_q,
                          fit_count(found_q), popped_q};

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer: command decode, shift loops and find scan.
  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    at_d     = at_q;
    val_d    = val_q;
    is_pop_d = is_pop_q;
    popped_d = popped_q;
    found_d  = found_q;
    status_d = status_q;
    rd_en    = 1'b0;
    rd_addr  = idx_q[CAP_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = idx_q[CAP_W-1:0];
    wr_data  = rdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          popped_d = '0;
          found_d  = '0;
          status_d = STS_OK;
          val_d    = in_val;
          is_pop_d = 1'b0;
          state_d  = ST_OUT;
          unique case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                at_d    = (in_cmd == CMD_PUSH_FRONT) ? '0 : CAP_W'(occ_q);
                idx_d   = occ_q;
                state_d = ST_INS_RD;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                popped_d = '1;
                status_d = STS_EMPTY;
              end else begin
                at_d     = (in_cmd == CMD_POP_FRONT) ? '0 : CAP_W'(occ_q - 1'b1);
                idx_d    = (in_cmd == CMD_POP_FRONT) ? '0 : occ_q - 1'b1;
                is_pop_d = 1'b1;
                state_d  = ST_TAKE;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                status_d = STS_FULL;
              end else if (pos_w == '0 || pos_w > occ_w + 1'b1) begin
                status_d = STS_BADPOS;
              end else begin
                at_d    = CAP_W'(pos_w - 1'b1);
                idx_d   = occ_q;
                state_d = ST_INS_RD;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                status_d = STS_EMPTY;
              end else if (pos_w == '0 || pos_w > occ_w) begin
                status_d = STS_BADPOS;
              end else begin
                at_d    = CAP_W'(pos_w - 1'b1);
                idx_d   = CNT_W'(pos_w - 1'b1);
                state_d = ST_TAKE;
              end
            end
            CMD_FIND: begin
              idx_d   = '0;
              state_d = ST_FIND_RD;
            end
            default: begin
              // Unused command code: report ok and change nothing.
              status_d = STS_OK;
            end
          endcase
        end
      end

      // Open a gap: move entries up one slot, top first, then place the value.
      ST_INS_RD: begin
        if (idx_q[CAP_W-1:0] == at_q) begin
          wr_en   = 1'b1;
          wr_addr = at_q;
          wr_data = val_q;
          occ_d   = occ_q + 1'b1;
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = CAP_W'(idx_q - 1'b1);
          state_d = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[CAP_W-1:0];
        idx_d   = idx_q - 1'b1;
        state_d = ST_INS_RD;
      end

      // Read the entry being removed; pops return it.
      ST_TAKE: begin
        rd_en   = 1'b1;
        rd_addr = at_q;
        state_d = ST_TAKE_CAP;
      end
      ST_TAKE_CAP: begin
        popped_d = is_pop_q ? rdata_q : '0;
        state_d  = ST_DEL_RD;
      end

      // Close the gap: move entries down one slot, bottom first.
      ST_DEL_RD: begin
        if (idx_q + 1'b1 == occ_q) begin
          occ_d   = occ_q - 1'b1;
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = CAP_W'(idx_q + 1'b1);
          state_d = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[CAP_W-1:0];
        idx_d   = idx_q + 1'b1;
        state_d = ST_DEL_RD;
      end

      // Scan from the front with one comparator until a match or the end.
      ST_FIND_RD: begin
        if (idx_q == occ_q) begin
          found_d  = occ_q;
          status_d = STS_NOTFOUND;
          state_d  = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q[CAP_W-1:0];
          state_d = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        if (rdata_q == val_q) begin
          found_d  = idx_q;
          status_d = STS_OK;
          state_d  = ST_OUT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FIND_RD;
        end
      end

      // Hold the result beat until the receiver takes it.
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    at_q     <= at_d;
    val_q    <= val_d;
    is_pop_q <= is_pop_d;
    popped_q <= popped_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  // The element count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // The block never offers a result while it takes a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready and result valid at once");

  // Once a result beat is taken the block is ready next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not idle after result beat");

  // The count holds while the block sits idle without a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && !s_axis_tvalid) |=> $stable(occ_q))
    else $error("count changed while idle");

  // A command changes the count by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_OUT) |=>
      (occ_q == $past(occ_q) || occ_q == $past(occ_q) + 1'b1 ||
       occ_q == $past(occ_q) - 1'b1))
    else $error("count stepped by more than one");

endmodule
